/* rtl/spct_pkg.sv */
// spct_pkg: constants and helpers for the spherical to cartesian state converter
// holds the cordic arctangent table, datapath widths and the output clip function
// no dependencies
`default_nettype none
package spct_pkg;

    localparam int CORDIC_MAX_STEPS = 24;
    localparam int XW = 34;   // cordic x/y and trig coefficient width, Q2.30 with headroom
    localparam int ZW = 33;   // cordic residual angle width
    localparam int WW = 49;   // rounded R*rate width, Q16.16
    localparam int TW = 48;   // width of one rounded velocity/position term
    localparam int SW = 50;   // width of a term sum before clipping

    localparam logic signed [XW-1:0] CORDIC_X0 = 34'sd652032874;

    localparam logic [31:0] ATAN_TAB [CORDIC_MAX_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic        hit;
        logic [31:0] value;
    } clip_t;

    function automatic clip_t clip32(input logic signed [SW-1:0] v);
        clip_t res;
        res.hit   = 1'b0;
        res.value = v[31:0];
        if (v > SW'(32'sh7FFFFFFF)) begin
            res.hit   = 1'b1;
            res.value = 32'h7FFFFFFF;
        end else if (v < SW'(32'sh80000000)) begin
            res.hit   = 1'b1;
            res.value = 32'h80000000;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* rtl/spherical_to_cartesian_state.sv */
// spherical_to_cartesian_state: spherical position and rates in, cartesian position
// and velocity out, as a fully pipelined cordic and multiplier datapath
// depends on spct_pkg
//
// One beat is taken every clock cycle while the skid register is empty. Each beat passes
// through one input stage, one cordic stage per iteration (both angles
// in parallel), then seven stages of sign fixup, products, rounding, sums and clipping.
// The whole pipeline advances together; a two-entry output (final stage plus skid
// register) keeps input beats flowing while one result waits for m_tready, and the
// pipeline holds only once the skid register is full. Out-of-range polar angles are
// replaced by pi/2 and flagged in m_tuser; a negative radius is folded to its magnitude.
`default_nettype none
module spherical_to_cartesian_state #(
    parameter int SINCOS_STEPS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // radius[31:0] azimuth[47:32] polar[63:48] radius_rate[95:64]
    // azimuth_rate[127:96] polar_rate[159:128]
    input  wire logic [159:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pos_x[31:0] pos_y[63:32] pos_z[95:64] vel_x[127:96] vel_y[159:128] vel_z[191:160]
    output logic [191:0]      m_tdata,
    // polar_replaced[0] velocity_saturated[1]
    output logic [1:0]        m_tuser
);
    import spct_pkg::*;

    localparam int NS = (SINCOS_STEPS < 1) ? 1 :
                        ((SINCOS_STEPS > CORDIC_MAX_STEPS) ? CORDIC_MAX_STEPS : SINCOS_STEPS);
    localparam int NSTG = NS + 8;

    logic ce;
    logic [NSTG-1:0] v_reg;
    logic skid_v_reg;

    assign ce       = !skid_v_reg;
    assign s_tready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[NSTG-2:0], s_tvalid};
        end
    end

    // input fold
    logic signed [31:0] r_in;
    logic [15:0] az_in, po_in, po_a, az_f, po_f;
    logic repl_in, neg_in, flip_t_in, flip_p_in;
    logic signed [32:0] r_mag;
    logic [15:0] zt16, zp16;

    always_comb begin
        r_in    = s_tdata[31:0];
        az_in   = s_tdata[47:32];
        po_in   = s_tdata[63:48];
        repl_in = po_in > 16'd32768;
        po_a    = repl_in ? 16'd16384 : po_in;
        neg_in  = r_in[31];
        r_mag   = neg_in ? -{r_in[31], r_in} : {r_in[31], r_in};
        az_f    = neg_in ? az_in + 16'h8000 : az_in;
        po_f    = neg_in ? 16'h8000 - po_a : po_a;
        flip_t_in = az_f[15] ^ az_f[14];
        flip_p_in = po_f[15] ^ po_f[14];
        zt16    = {az_f[15] ^ flip_t_in, az_f[14:0]};
        zp16    = {po_f[15] ^ flip_p_in, po_f[14:0]};
    end

    // cordic stages 0..NS with payload alongside
    logic signed [XW-1:0] xt_reg [NS+1];
    logic signed [XW-1:0] yt_reg [NS+1];
    logic signed [ZW-1:0] zt_reg [NS+1];
    logic signed [XW-1:0] xp_reg [NS+1];
    logic signed [XW-1:0] yp_reg [NS+1];
    logic signed [ZW-1:0] zp_reg [NS+1];
    logic signed [32:0]   r_reg  [NS+1];
    logic signed [31:0]   dr_reg [NS+1];
    logic signed [31:0]   dt_reg [NS+1];
    logic signed [31:0]   dp_reg [NS+1];
    logic                 repl_reg [NS+1];
    logic                 ft_reg [NS+1];
    logic                 fp_reg [NS+1];

    always_ff @(posedge aclk) begin
        if (ce) begin
            xt_reg[0]   <= CORDIC_X0;
            yt_reg[0]   <= '0;
            zt_reg[0]   <= {zt16[15], zt16, 16'h0000};
            xp_reg[0]   <= CORDIC_X0;
            yp_reg[0]   <= '0;
            zp_reg[0]   <= {zp16[15], zp16, 16'h0000};
            r_reg[0]    <= r_mag;
            dr_reg[0]   <= s_tdata[95:64];
            dt_reg[0]   <= s_tdata[127:96];
            dp_reg[0]   <= s_tdata[159:128];
            repl_reg[0] <= repl_in;
            ft_reg[0]   <= flip_t_in;
            fp_reg[0]   <= flip_p_in;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++) begin : g_cordic
            localparam logic signed [ZW-1:0] ATAN = {1'b0, ATAN_TAB[gi]};
            always_ff @(posedge aclk) begin
                if (ce) begin
                    if (!zt_reg[gi][ZW-1]) begin
                        xt_reg[gi+1] <= xt_reg[gi] - (yt_reg[gi] >>> gi);
                        yt_reg[gi+1] <= yt_reg[gi] + (xt_reg[gi] >>> gi);
                        zt_reg[gi+1] <= zt_reg[gi] - ATAN;
                    end else begin
                        xt_reg[gi+1] <= xt_reg[gi] + (yt_reg[gi] >>> gi);
                        yt_reg[gi+1] <= yt_reg[gi] - (xt_reg[gi] >>> gi);
                        zt_reg[gi+1] <= zt_reg[gi] + ATAN;
                    end
                    if (!zp_reg[gi][ZW-1]) begin
                        xp_reg[gi+1] <= xp_reg[gi] - (yp_reg[gi] >>> gi);
                        yp_reg[gi+1] <= yp_reg[gi] + (xp_reg[gi] >>> gi);
                        zp_reg[gi+1] <= zp_reg[gi] - ATAN;
                    end else begin
                        xp_reg[gi+1] <= xp_reg[gi] + (yp_reg[gi] >>> gi);
                        yp_reg[gi+1] <= yp_reg[gi] - (xp_reg[gi] >>> gi);
                        zp_reg[gi+1] <= zp_reg[gi] + ATAN;
                    end
                    r_reg[gi+1]    <= r_reg[gi];
                    dr_reg[gi+1]   <= dr_reg[gi];
                    dt_reg[gi+1]   <= dt_reg[gi];
                    dp_reg[gi+1]   <= dp_reg[gi];
                    repl_reg[gi+1] <= repl_reg[gi];
                    ft_reg[gi+1]   <= ft_reg[gi];
                    fp_reg[gi+1]   <= fp_reg[gi];
                end
            end
        end
    endgenerate

    // q1: undo the half-turn, R times angle rates
    logic signed [XW-1:0] ct1_reg, st1_reg, cp1_reg, sp1_reg;
    logic signed [64:0]   wtr1_reg, wpr1_reg;
    logic signed [32:0]   r1_reg;
    logic signed [31:0]   dr1_reg;
    logic                 repl1_reg;
    logic signed [64:0]   wtr_next, wpr_next;

    always_comb begin
        wtr_next = r_reg[NS] * dt_reg[NS];
        wpr_next = r_reg[NS] * dp_reg[NS];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ct1_reg   <= ft_reg[NS] ? -xt_reg[NS] : xt_reg[NS];
            st1_reg   <= ft_reg[NS] ? -yt_reg[NS] : yt_reg[NS];
            cp1_reg   <= fp_reg[NS] ? -xp_reg[NS] : xp_reg[NS];
            sp1_reg   <= fp_reg[NS] ? -yp_reg[NS] : yp_reg[NS];
            wtr1_reg  <= wtr_next;
            wpr1_reg  <= wpr_next;
            r1_reg    <= r_reg[NS];
            dr1_reg   <= dr_reg[NS];
            repl1_reg <= repl_reg[NS];
        end
    end

    // q2: trig products, round R*rate to Q16.16
    logic signed [2*XW-1:0] pcs2_reg, pss2_reg, pcc2_reg, psc2_reg;
    logic signed [2*XW-1:0] pcs_next, pss_next, pcc_next, psc_next;
    logic signed [64:0]     wtn_next, wpn_next;
    logic signed [WW-1:0]   wt2_reg, wp2_reg;
    logic signed [XW-1:0]   cp2_reg, sp2_reg;
    logic signed [32:0]     r2_reg;
    logic signed [31:0]     dr2_reg;
    logic                   repl2_reg;

    always_comb begin
        pcs_next = ct1_reg * sp1_reg;
        pss_next = st1_reg * sp1_reg;
        pcc_next = ct1_reg * cp1_reg;
        psc_next = st1_reg * cp1_reg;
        wtn_next = wtr1_reg + 65'sd32768;
        wpn_next = wpr1_reg + 65'sd32768;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            pcs2_reg  <= pcs_next;
            pss2_reg  <= pss_next;
            pcc2_reg  <= pcc_next;
            psc2_reg  <= psc_next;
            wt2_reg   <= wtn_next[64:16];
            wp2_reg   <= wpn_next[64:16];
            cp2_reg   <= cp1_reg;
            sp2_reg   <= sp1_reg;
            r2_reg    <= r1_reg;
            dr2_reg   <= dr1_reg;
            repl2_reg <= repl1_reg;
        end
    end

    // q3: round trig products to Q2.30, split the wide rate terms
    logic signed [2*XW-1:0] rcs_next, rss_next, rcc_next, rsc_next;
    logic signed [XW-1:0]   cs3_reg, ss3_reg, cc3_reg, sc3_reg, cp3_reg, sp3_reg;
    logic signed [WW-17:0]  wth3_reg, wph3_reg;
    logic signed [16:0]     wtl3_reg, wpl3_reg;
    logic signed [32:0]     r3_reg;
    logic signed [31:0]     dr3_reg;
    logic                   repl3_reg;

    always_comb begin
        rcs_next = pcs2_reg + 68'sd536870912;
        rss_next = pss2_reg + 68'sd536870912;
        rcc_next = pcc2_reg + 68'sd536870912;
        rsc_next = psc2_reg + 68'sd536870912;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            cs3_reg   <= rcs_next[XW+29:30];
            ss3_reg   <= rss_next[XW+29:30];
            cc3_reg   <= rcc_next[XW+29:30];
            sc3_reg   <= rsc_next[XW+29:30];
            cp3_reg   <= cp2_reg;
            sp3_reg   <= sp2_reg;
            wth3_reg  <= wt2_reg[WW-1:16];
            wph3_reg  <= wp2_reg[WW-1:16];
            wtl3_reg  <= {1'b0, wt2_reg[15:0]};
            wpl3_reg  <= {1'b0, wp2_reg[15:0]};
            r3_reg    <= r2_reg;
            dr3_reg   <= dr2_reg;
            repl3_reg <= repl2_reg;
        end
    end

    // q4: all multiplies by Q2.30 coefficients
    localparam int PW = 33 + XW;
    localparam int LW = 17 + XW;
    logic signed [PW-1:0] prcs4_reg, prss4_reg, prcp4_reg, pdcs4_reg, pdss4_reg, pdcp4_reg;
    logic signed [PW-1:0] htss4_reg, htcs4_reg, hpcc4_reg, hpsc4_reg, hpsp4_reg;
    logic signed [LW-1:0] ltss4_reg, ltcs4_reg, lpcc4_reg, lpsc4_reg, lpsp4_reg;
    logic                 repl4_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            prcs4_reg <= r3_reg * cs3_reg;
            prss4_reg <= r3_reg * ss3_reg;
            prcp4_reg <= r3_reg * cp3_reg;
            pdcs4_reg <= dr3_reg * cs3_reg;
            pdss4_reg <= dr3_reg * ss3_reg;
            pdcp4_reg <= dr3_reg * cp3_reg;
            htss4_reg <= wth3_reg * ss3_reg;
            htcs4_reg <= wth3_reg * cs3_reg;
            hpcc4_reg <= wph3_reg * cc3_reg;
            hpsc4_reg <= wph3_reg * sc3_reg;
            hpsp4_reg <= wph3_reg * sp3_reg;
            ltss4_reg <= wtl3_reg * ss3_reg;
            ltcs4_reg <= wtl3_reg * cs3_reg;
            lpcc4_reg <= wpl3_reg * cc3_reg;
            lpsc4_reg <= wpl3_reg * sc3_reg;
            lpsp4_reg <= wpl3_reg * sp3_reg;
            repl4_reg <= repl3_reg;
        end
    end

    // q5: join partial products and round each term by 2^30
    localparam int FW = PW + 17;

    function automatic logic signed [TW-1:0] rnd_direct(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = p + PW'(36'sd536870912);
        return TW'(s >>> 30);
    endfunction

    function automatic logic signed [TW-1:0] rnd_split(input logic signed [PW-1:0] h,
                                                       input logic signed [LW-1:0] l);
        logic signed [FW-1:0] s;
        s = (FW'(h) <<< 16) + FW'(l) + FW'(36'sd536870912);
        return TW'(s >>> 30);
    endfunction

    logic signed [TW-1:0] trcs5_reg, trss5_reg, trcp5_reg, tdcs5_reg, tdss5_reg, tdcp5_reg;
    logic signed [TW-1:0] ttss5_reg, ttcs5_reg, tpcc5_reg, tpsc5_reg, tpsp5_reg;
    logic                 repl5_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            trcs5_reg <= rnd_direct(prcs4_reg);
            trss5_reg <= rnd_direct(prss4_reg);
            trcp5_reg <= rnd_direct(prcp4_reg);
            tdcs5_reg <= rnd_direct(pdcs4_reg);
            tdss5_reg <= rnd_direct(pdss4_reg);
            tdcp5_reg <= rnd_direct(pdcp4_reg);
            ttss5_reg <= rnd_split(htss4_reg, ltss4_reg);
            ttcs5_reg <= rnd_split(htcs4_reg, ltcs4_reg);
            tpcc5_reg <= rnd_split(hpcc4_reg, lpcc4_reg);
            tpsc5_reg <= rnd_split(hpsc4_reg, lpsc4_reg);
            tpsp5_reg <= rnd_split(hpsp4_reg, lpsp4_reg);
            repl5_reg <= repl4_reg;
        end
    end

    // q6: velocity sums, positions passed through
    logic signed [SW-1:0] px6_reg, py6_reg, pz6_reg, vx6_reg, vy6_reg, vz6_reg;
    logic                 repl6_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            px6_reg   <= SW'(trcs5_reg);
            py6_reg   <= SW'(trss5_reg);
            pz6_reg   <= SW'(trcp5_reg);
            vx6_reg   <= SW'(tdcs5_reg) - SW'(ttss5_reg) + SW'(tpcc5_reg);
            vy6_reg   <= SW'(tdss5_reg) + SW'(ttcs5_reg) + SW'(tpsc5_reg);
            vz6_reg   <= SW'(tdcp5_reg) - SW'(tpsp5_reg);
            repl6_reg <= repl5_reg;
        end
    end

    // final stage: clip, then skid register
    clip_t cpx, cpy, cpz, cvx, cvy, cvz;
    logic [191:0] fin_data_reg, skid_data_reg;
    logic [1:0]   fin_user_reg, skid_user_reg;

    always_comb begin
        cpx = clip32(px6_reg);
        cpy = clip32(py6_reg);
        cpz = clip32(pz6_reg);
        cvx = clip32(vx6_reg);
        cvy = clip32(vy6_reg);
        cvz = clip32(vz6_reg);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            fin_data_reg <= {cvz.value, cvy.value, cvx.value, cpz.value, cpy.value, cpx.value};
            fin_user_reg <= {cvx.hit | cvy.hit | cvz.hit, repl6_reg};
        end
    end

    // park the final beat when it is not taken while the pipeline moves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (m_tready) begin
                skid_v_reg <= 1'b0;
            end
        end else if (v_reg[NSTG-1] && !m_tready) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_v_reg) begin
            skid_data_reg <= fin_data_reg;
            skid_user_reg <= fin_user_reg;
        end
    end

    assign m_tvalid = skid_v_reg | v_reg[NSTG-1];
    assign m_tdata  = skid_v_reg ? skid_data_reg : fin_data_reg;
    assign m_tuser  = skid_v_reg ? skid_user_reg : fin_user_reg;

endmodule
`default_nettype wire
